>>> src/wac_pkg.sv
// wac_pkg: shared constants and the beat type that travels along the
// coalescer's cell chain. No dependencies.
package wac_pkg;

    // Field and state widths
    localparam int OFFSET_W = 32;
    localparam int RANGE_W  = 34;
    localparam int SEG_W    = 13;
    localparam int COUNT_W  = 6;

    // Table size and fixed sizes
    localparam int RANGE_SLOTS  = 32;
    localparam int ACCESS_BYTES = 4;

    localparam logic [SEG_W-1:0]   SEGMENT_RESET = SEG_W'(256);
    localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};

    // One thread access moving down the chain
    typedef struct packed {
        logic                valid;
        logic [OFFSET_W-1:0] offset;
        logic                known;
        logic                last;
        logic                done;   // placed in some range already
        logic [COUNT_W-1:0]  count;  // ranges counted by the flush of a last beat
    } beat_t;

endpackage

>>> src/wac_cell.sv
// wac_cell: one range slot of the coalescer chain. Holds one [start, end]
// range, tests the passing beat against it and hands the beat on.
// Depends on wac_pkg.
module wac_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [wac_pkg::SEG_W-1:0]     seg,
    input  wac_pkg::beat_t                beat_in,
    output wac_pkg::beat_t                beat_out
);

    localparam int CW = wac_pkg::RANGE_W + 1;

    logic                          valid_reg, valid_next;
    logic [wac_pkg::RANGE_W-1:0]   start_reg, start_next;
    logic [wac_pkg::RANGE_W-1:0]   end_reg, end_next;
    wac_pkg::beat_t                beat_reg, beat_next;

    logic signed [CW-1:0] off_w, off_end, s_w, e_w, seg_w;
    logic                 active, covers, grow_lo, grow_hi, fill, take, occupied;

    // Signed operands, one bit of headroom
    assign off_w   = {{(CW-wac_pkg::OFFSET_W){beat_in.offset[wac_pkg::OFFSET_W-1]}},
                      beat_in.offset};
    assign off_end = off_w + CW'(wac_pkg::ACCESS_BYTES);
    assign s_w     = {start_reg[wac_pkg::RANGE_W-1], start_reg};
    assign e_w     = {end_reg[wac_pkg::RANGE_W-1], end_reg};
    assign seg_w   = {{(CW-wac_pkg::SEG_W){1'b0}}, seg};

    // Range tests, in priority order of the slot
    assign active  = beat_in.valid && beat_in.known && !beat_in.done;
    assign covers  = (off_w >= s_w) && (off_w <= e_w);
    assign grow_lo = (off_w < s_w) && (off_w >= e_w - seg_w);
    assign grow_hi = (off_end > e_w) && (off_end <= s_w + seg_w);
    assign fill    = active && !valid_reg;
    assign take    = active && valid_reg && (covers || grow_lo || grow_hi);

    // Slot update and flush on the warp's last beat
    always_comb
    begin
        valid_next = valid_reg;
        start_next = start_reg;
        end_next   = end_reg;
        beat_next  = beat_in;
        occupied   = valid_reg || fill;
        if (fill)
        begin
            valid_next = 1'b1;
            start_next = off_w[wac_pkg::RANGE_W-1:0];
            end_next   = off_end[wac_pkg::RANGE_W-1:0];
        end
        else if (take && !covers && grow_lo)
        begin
            start_next = off_w[wac_pkg::RANGE_W-1:0];
        end
        else if (take && !covers)
        begin
            end_next = off_end[wac_pkg::RANGE_W-1:0];
        end
        beat_next.done = beat_in.done || fill || take;
        if (beat_in.valid && beat_in.last)
        begin
            valid_next      = 1'b0;
            beat_next.count = beat_in.count + wac_pkg::COUNT_W'(occupied);
        end
        if (!beat_in.valid)
        begin
            valid_next = valid_reg;
            start_next = start_reg;
            end_next   = end_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    // Range bounds, meaningful only while valid
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    assign beat_out = beat_reg;

endmodule

>>> src/warp_access_coalescer.sv
// warp_access_coalescer: counts the memory requests of one warp from its
// threads' byte offsets, using a chain of range cells. Depends on wac_pkg, wac_cell.
// The last thread's beat passes through every cell, then the output register, to request_count.
// Throughput: one thread beat per cycle while in_stall is low; each beat passes every cell in turn.
// The chain halts only while a finished result waits on a stalled output.
// Reset: empties every slot, clears the beat and unknown counts (not request_count), seg_reg returns to 256.
module warp_access_coalescer #(
    parameter int RANGE_SLOTS = wac_pkg::RANGE_SLOTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [wac_pkg::SEG_W-1:0]          cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [wac_pkg::OFFSET_W-1:0] thread_offset,
    input  logic                               offset_known,
    input  logic                               last_thread,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [wac_pkg::COUNT_W-1:0]        request_count
);

    logic [wac_pkg::SEG_W-1:0]   seg_reg;
    logic [wac_pkg::COUNT_W-1:0] unk_reg, unk_next, unk_after;
    logic [wac_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        stall_chain, tail_go, tail_unplaced;
    logic [wac_pkg::COUNT_W:0]   total;
    wac_pkg::beat_t              head;
    wac_pkg::beat_t              chain [0:RANGE_SLOTS];
    wac_pkg::beat_t              tail;

    // Segment size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_reg <= wac_pkg::SEGMENT_RESET;
        else if (cfg_we)
            seg_reg <= cfg_wdata;
    end

    // Beat entering the chain
    always_comb
    begin
        head        = '0;
        head.valid  = in_valid;
        head.offset = thread_offset;
        head.known  = offset_known;
        head.last   = last_thread;
    end

    assign chain[0] = head;

    // Cell chain
    for (genvar k = 0; k < RANGE_SLOTS; k++)
    begin : g_cell
        wac_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (!stall_chain),
            .seg      (seg_reg),
            .beat_in  (chain[k]),
            .beat_out (chain[k+1])
        );
    end

    assign tail = chain[RANGE_SLOTS];

    // Hold the chain only when a result is due and the output is still full
    assign stall_chain = tail.valid && tail.last && out_valid_reg && out_stall;
    assign in_stall    = stall_chain;
    assign tail_go     = tail.valid && !stall_chain;

    // Unknown accesses and accesses that found no free slot
    assign tail_unplaced = !tail.known || !tail.done;
    assign unk_after = (tail_unplaced && unk_reg != wac_pkg::COUNT_MAX) ?
                       unk_reg + wac_pkg::COUNT_W'(1) : unk_reg;
    assign total     = {1'b0, tail.count} + {1'b0, unk_after};

    always_comb
    begin
        unk_next       = unk_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (tail_go)
        begin
            unk_next = unk_after;
            if (tail.last)
            begin
                unk_next       = '0;
                out_valid_next = 1'b1;
                count_next     = total[wac_pkg::COUNT_W] ? wac_pkg::COUNT_MAX
                                                         : total[wac_pkg::COUNT_W-1:0];
            end
        end
    end

    // Tail counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unk_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unk_reg       <= unk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

    assign out_valid     = out_valid_reg;
    assign request_count = count_reg;

    // A last beat leaving the chain always yields a result beat
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_go && tail.last) |=> out_valid_reg)
        else $error("last beat left the chain without a result");

    // Input is held back only by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    // Unknown count restarts with each warp
    a_unk_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_go && tail.last) |=> (unk_reg == '0))
        else $error("unknown count not cleared after warp end");

    // A stalled chain does not move
    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stall_chain |=> $stable(tail))
        else $error("chain tail changed while halted");

endmodule

>>> dv/warp_access_coalescer_tb.sv
// warp_access_coalescer_tb: self-checking bench for the warp access coalescer.
// Tallies each warp's expected request count from thread beats and checks
// request_count as results come out. Depends on wac_pkg and warp_access_coalescer.
module warp_access_coalescer_tb;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [wac_pkg::SEG_W-1:0]           cfg_wdata;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [wac_pkg::OFFSET_W-1:0] thread_offset;
    logic                                offset_known;
    logic                                last_thread;
    logic                                out_valid;
    logic                                out_stall;
    logic [wac_pkg::COUNT_W-1:0]         request_count;

    // Per-phase idle rates, percent of cycles
    int unsigned send_gap_pct;
    int unsigned out_stall_pct;
    int unsigned mismatches;

    // Expected warp tallies, oldest first
    logic [wac_pkg::COUNT_W-1:0] pending_counts[$];

    // Shadow copy of the coalescing table
    longint                    span_lo[wac_pkg::RANGE_SLOTS];
    longint                    span_hi[wac_pkg::RANGE_SLOTS];
    int unsigned               spans_open;
    int unsigned               unknown_reqs;
    logic [wac_pkg::SEG_W-1:0] seg_limit;

    warp_access_coalescer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .thread_offset (thread_offset),
        .offset_known  (offset_known),
        .last_thread   (last_thread),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .request_count (request_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Coalescing predictor
    // ---------------------------------------------------------------
    function automatic void count_unknown();
        if (unknown_reqs < wac_pkg::COUNT_MAX)
            unknown_reqs++;
    endfunction

    // The first range that covers the offset or can stretch down or up within the
    // segment wins, else a new 4-byte range, or an unknown request if the table is full.
    function automatic void place_access(longint off);
        longint seg;
        bit     placed;
        seg = longint'(seg_limit);
        placed = 1'b0;
        for (int k = 0; k < spans_open && !placed; k++)
        begin
            if (off >= span_lo[k] && off <= span_hi[k])
            begin
                placed = 1'b1;
            end
            else if (off < span_lo[k] && off >= span_hi[k] - seg)
            begin
                span_lo[k] = off;
                placed = 1'b1;
            end
            else if (off + wac_pkg::ACCESS_BYTES > span_hi[k] &&
                     off + wac_pkg::ACCESS_BYTES <= span_lo[k] + seg)
            begin
                span_hi[k] = off + wac_pkg::ACCESS_BYTES;
                placed = 1'b1;
            end
        end
        if (!placed)
        begin
            if (spans_open < wac_pkg::RANGE_SLOTS)
            begin
                span_lo[spans_open] = off;
                span_hi[spans_open] = off + wac_pkg::ACCESS_BYTES;
                spans_open++;
            end
            else
            begin
                count_unknown();
            end
        end
    endfunction

    function automatic void tally_thread(logic signed [wac_pkg::OFFSET_W-1:0] off, bit known,
                                         bit last);
        int unsigned total;
        if (known)
            place_access(longint'(off));
        else
            count_unknown();
        if (last)
        begin
            total = spans_open + unknown_reqs;
            if (total > wac_pkg::COUNT_MAX)
                total = wac_pkg::COUNT_MAX;
            pending_counts = {pending_counts, wac_pkg::COUNT_W'(total)};
            spans_open = 0;
            unknown_reqs = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    // Send one thread beat; valid stays high afterwards unless a gap is drawn
    task automatic send_thread(logic signed [wac_pkg::OFFSET_W-1:0] off, bit known, bit last);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        thread_offset <= off;
        offset_known  <= known;
        last_thread   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tally_thread(off, known, last);
    endtask

    // Drop valid, wait for every tally to come back, then let the chain drain
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (wac_pkg::RANGE_SLOTS + 8) @(posedge clk);
    endtask

    task automatic set_segment(logic [wac_pkg::SEG_W-1:0] bytes);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= bytes;
        @(negedge clk);
        cfg_we    <= 1'b0;
        seg_limit = bytes;
    endtask

    // Receiver stall
    always @(negedge clk)
        out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        logic [wac_pkg::COUNT_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("request_count: expected none, actual %0d", request_count);
                mismatches++;
            end
            else
            begin
                want = pending_counts.pop_front();
                if (request_count !== want)
                begin
                    $error("request_count: expected %0d, actual %0d", want, request_count);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset segment of 256: end stretch to exactly the limit, then an offset on the end bound, which is covered
    task automatic test_reset_segment();
        send_thread(32'sd0, 1'b1, 1'b0);
        send_thread(32'sd252, 1'b1, 1'b0);
        send_thread(32'sd256, 1'b1, 1'b0);
        send_thread(32'sd4, 1'b1, 1'b0);
        send_thread(32'sd77, 1'b0, 1'b0);
        send_thread(-32'sd4, 1'b1, 1'b1);
    endtask

    // Offset extremes and a one-thread warp
    task automatic test_offset_extremes();
        send_thread(32'sh7FFF_FFFF, 1'b1, 1'b0);
        send_thread(32'sh8000_0000, 1'b1, 1'b0);
        send_thread(32'shFFFF_FFFF, 1'b1, 1'b0);
        send_thread(32'sh7FFF_FFFC, 1'b1, 1'b0);
        send_thread(32'sh0000_0000, 1'b1, 1'b1);
        send_thread(32'shFFFF_FFFF, 1'b0, 1'b1);
    endtask

    // Segment sizes at the limits and between, zero included
    task automatic test_segment_extremes();
        logic [wac_pkg::SEG_W-1:0] sizes[4];
        sizes = '{13'd0, 13'd1, 13'd4096, 13'd8191};
        foreach (sizes[i])
        begin
            set_segment(sizes[i]);
            send_thread(32'sd1000, 1'b1, 1'b0);
            send_thread(32'sd1004, 1'b1, 1'b0);
            send_thread(32'sd996, 1'b1, 1'b0);
            send_thread(32'sd5000, 1'b1, 1'b1);
        end
    endtask

    // Table full: spread-out offsets overflow into separate requests
    task automatic test_table_full();
        set_segment(13'd4);
        for (int t = 0; t < wac_pkg::RANGE_SLOTS + 2; t++)
            send_thread(32'(t * 64), 1'b1, t == wac_pkg::RANGE_SLOTS + 1);
    endtask

    // Count saturation, also a warp whose last thread is long in coming
    task automatic test_count_saturation();
        for (int t = 0; t < 70; t++)
            send_thread($urandom, 1'b0, t == 69);
        for (int t = 0; t < 72; t++)
            send_thread(32'(t * 128), t < 36, t == 71);
    endtask

    // Well-formed warps of clustered offsets, with some scattered warps
    task automatic run_random_warps(int unsigned n_items);
        int unsigned        sent;
        int unsigned        len;
        int unsigned        span;
        logic signed [31:0] base;
        logic signed [31:0] off;
        bit                 scatter;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(9))
                0:       len = $urandom_range(33, 45);
                1:       len = $urandom_range(1, 3);
                default: len = $urandom_range(4, 32);
            endcase
            scatter = ($urandom_range(3) == 0);
            base    = $urandom;
            span    = 4 << $urandom_range(1, 11);
            for (int t = 0; t < len; t++)
            begin
                if (scatter)
                    off = $urandom;
                else
                    off = base + 32'($urandom_range(0, span));
                if ($urandom_range(1))
                    off[1:0] = 2'b00;
                send_thread(off, $urandom_range(9) != 0, t == len - 1);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic(int unsigned gap_pct, int unsigned stall_pct,
                                       logic [wac_pkg::SEG_W-1:0] bytes,
                                       int unsigned n_items);
        set_segment(bytes);
        send_gap_pct  = gap_pct;
        out_stall_pct = stall_pct;
        run_random_warps(n_items);
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        thread_offset = '0;
        offset_known  = 1'b0;
        last_thread   = 1'b0;
        send_gap_pct  = 7;
        out_stall_pct = 64;
        spans_open    = 0;
        unknown_reqs  = 0;
        seg_limit     = wac_pkg::SEGMENT_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_segment();
        test_offset_extremes();
        test_segment_extremes();
        test_table_full();
        test_count_saturation();
        test_random_traffic(7, 64, 13'($urandom_range(16, 1024)), 380);
        test_random_traffic(64, 7, 13'd4096, 380);
        test_random_traffic(0, 0, 13'($urandom_range(1, 4096)), 380);
        wait_idle();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Run limit
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
src/wac_pkg.sv
src/wac_cell.sv
src/warp_access_coalescer.sv
dv/warp_access_coalescer_tb.sv
